[src/multi_mode_battery_charge_controller_defines.svh]
// assertion macros for the battery charge controller checker
// used by mmbcc_checker.sv; depends on a clock and reset in the using scope
`ifndef MULTI_MODE_BATTERY_CHARGE_CONTROLLER_DEFINES_SVH
`define MULTI_MODE_BATTERY_CHARGE_CONTROLLER_DEFINES_SVH

// checked every edge outside reset
`define MMBCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked every edge, reset included
`define MMBCC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[src/mmbcc_pkg.sv]
// shared types, codes and constants of the battery charge controller
// no dependencies
`default_nettype none

package mmbcc_pkg;

   localparam int FULL_CONFIRM_TICKS  = 30;
   localparam int LONG_RECHARGE_TICKS = 200;
   localparam int AGM_RECHARGE_TICKS  = 30;

   localparam int VOLT_W  = 12;
   localparam int TEMP_W  = 8;
   localparam int MODE_W  = 3;
   localparam int PHASE_W = 2;
   localparam int CSR_INDEX_W = 2;

   // charge modes
   localparam logic [MODE_W-1:0] MODE_STANDBY = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LEAD    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_AGM     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LITHIUM = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SIX     = 3'd4;

   // charge phases
   localparam logic [PHASE_W-1:0] PHASE_REMOVAL = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_BATTERY = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_CC      = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_FULL    = 2'd3;

   // phase requests
   localparam logic [1:0] REQ_NONE    = 2'd0;
   localparam logic [1:0] REQ_REMOVAL = 2'd1;
   localparam logic [1:0] REQ_BATTERY = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_MODE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD_RECHARGE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIX_STOP         = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIX_RECHARGE     = 2'd3;

   localparam logic [VOLT_W-1:0] LEAD_RECHARGE_RESET = 12'd1250;
   localparam logic [VOLT_W-1:0] SIX_STOP_RESET      = 12'd700;
   localparam logic [VOLT_W-1:0] SIX_RECHARGE_RESET  = 12'd500;

   typedef struct packed {
      logic [MODE_W-1:0] charge_mode;
      logic [VOLT_W-1:0] lead_recharge_level;
      logic [VOLT_W-1:0] six_volt_stop_level;
      logic [VOLT_W-1:0] six_volt_recharge_level;
   } mmbcc_cfg_type;

   typedef struct packed {
      logic [VOLT_W-1:0]        battery_voltage;
      logic signed [TEMP_W-1:0] temperature;
      logic                     fault_present;
      logic [1:0]               phase_request;
   } mmbcc_item_type;

   typedef struct packed {
      logic               charger_enable;
      logic               high_current;
      logic [PHASE_W-1:0] phase;
      logic [VOLT_W-1:0]  stop_threshold;
   } mmbcc_result_type;

endpackage

`default_nettype wire

[src/multi_mode_battery_charge_controller.sv]
// Multi-mode battery charge controller. Each req_ beat is one control tick
// (voltage, temperature, fault, phase request) and gives exactly one rsp_ beat
// with charger enable, current select, phase and the stop level in use. One
// tick is taken per clock cycle while req_stall is low; a tick's result goes
// from the input register through the step logic into the result register
// and is offered on rsp_ from there. The rate is set by the phase and counter
// update in mmbcc_core, which every tick must see from the tick before. A skid
// entry behind the result register lets one more tick in while a result is
// stalled; req_stall rises only when the input register and the skid entry are
// both full. Configuration must be written through csr_ while idle, unchecked.
// depends on mmbcc_pkg and mmbcc_core
`default_nettype none

module multi_mode_battery_charge_controller
   import mmbcc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [VOLT_W-1:0]        csr_write_data,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [VOLT_W-1:0]        req_battery_voltage,
   input  wire logic signed [TEMP_W-1:0] req_temperature,
   input  wire logic                     req_fault_present,
   input  wire logic [1:0]               req_phase_request,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_charger_enable,
   output logic                          rsp_high_current,
   output logic [PHASE_W-1:0]            rsp_phase,
   output logic [VOLT_W-1:0]             rsp_stop_threshold
);

   mmbcc_cfg_type    cfg_ff;
   mmbcc_item_type   item_ff;
   logic             item_valid_ff;
   mmbcc_result_type out_ff;
   logic             out_valid_ff;
   mmbcc_result_type skid_ff;
   logic             skid_valid_ff;
   mmbcc_result_type step_result;
   logic             step;
   logic             req_take;
   logic             out_busy;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = item_valid_ff && skid_valid_ff;
   assign step      = item_valid_ff && !skid_valid_ff;
   assign out_busy  = out_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_mode             <= MODE_STANDBY;
         cfg_ff.lead_recharge_level     <= LEAD_RECHARGE_RESET;
         cfg_ff.six_volt_stop_level     <= SIX_STOP_RESET;
         cfg_ff.six_volt_recharge_level <= SIX_RECHARGE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CHARGE_MODE:   cfg_ff.charge_mode             <= csr_write_data[MODE_W-1:0];
            CSR_LEAD_RECHARGE: cfg_ff.lead_recharge_level     <= csr_write_data;
            CSR_SIX_STOP:      cfg_ff.six_volt_stop_level     <= csr_write_data;
            CSR_SIX_RECHARGE:  cfg_ff.six_volt_recharge_level <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_take) begin
         item_valid_ff <= 1'b1;
      end else if (step) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.battery_voltage <= req_battery_voltage;
         item_ff.temperature     <= req_temperature;
         item_ff.fault_present   <= req_fault_present;
         item_ff.phase_request   <= req_phase_request;
      end
   end

   mmbcc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (step_result)
   );

   // result register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_busy) begin
         out_valid_ff  <= skid_valid_ff || step;
         skid_valid_ff <= 1'b0;
      end else if (step) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_busy) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (step) begin
            out_ff <= step_result;
         end
      end else if (step) begin
         skid_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_charger_enable = out_ff.charger_enable;
   assign rsp_high_current   = out_ff.high_current;
   assign rsp_phase          = out_ff.phase;
   assign rsp_stop_threshold = out_ff.stop_threshold;

endmodule

`default_nettype wire

[src/mmbcc_core.sv]
// charge state and one-tick step logic of the battery charge controller
// depends on mmbcc_pkg
`default_nettype none

module mmbcc_core
   import mmbcc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire mmbcc_item_type   item,
   input  wire mmbcc_cfg_type    cfg,
   output mmbcc_result_type      result
);

   localparam logic [5:0] OVER_MAX  = 6'h3f;
   localparam logic [7:0] UNDER_MAX = 8'hff;
   localparam logic [5:0] FULL_LIM  = 6'(FULL_CONFIRM_TICKS);
   localparam logic [7:0] LONG_LIM  = 8'(LONG_RECHARGE_TICKS);
   localparam logic [7:0] AGM_LIM   = 8'(AGM_RECHARGE_TICKS);

   // lead/agm stop level: 1440 - (dT*18)/10 toward zero, clamped 1410..1500
   function automatic logic [VOLT_W-1:0] lead_level(input logic signed [TEMP_W-1:0] temp);
      logic signed [8:0] d;
      logic [7:0]        mag;
      logic [11:0]       prod;
      logic [24:0]       scaled;
      logic [8:0]        q;
      logic [11:0]       lvl;
      d      = $signed({temp[7], temp}) - 9'sd25;
      mag    = d[8] ? 8'(-d) : d[7:0];
      prod   = {4'd0, mag} * 12'd18;
      // divide by 10 as multiply by 6554/65536, exact for this range
      scaled = {13'd0, prod} * 25'd6554;
      q      = scaled[24:16];
      lvl    = d[8] ? (12'd1440 + {3'd0, q}) : (12'd1440 - {3'd0, q});
      if (lvl > 12'd1500) begin
         lvl = 12'd1500;
      end else if (lvl < 12'd1410) begin
         lvl = 12'd1410;
      end
      return lvl;
   endfunction

   // lithium stop level: 1460 - 4*dT, clamped 1400..1480
   function automatic logic [VOLT_W-1:0] lithium_level(input logic signed [TEMP_W-1:0] temp);
      logic signed [8:0]  d;
      logic signed [12:0] d4;
      logic signed [12:0] lvl;
      d   = $signed({temp[7], temp}) - 9'sd25;
      d4  = $signed({d[8], d[8], d, 2'b00});
      lvl = 13'sd1460 - d4;
      if (lvl > 13'sd1480) begin
         lvl = 13'sd1480;
      end else if (lvl < 13'sd1400) begin
         lvl = 13'sd1400;
      end
      return lvl[11:0];
   endfunction

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               current_ff, current_in;
   logic [VOLT_W-1:0]  latched_ff [3];
   logic [VOLT_W-1:0]  latched_in [3];
   logic [5:0]         over_ff [4];
   logic [5:0]         over_in [4];
   logic [7:0]         under_ff [3];
   logic [7:0]         under_in [3];

   logic [MODE_W-1:0]  mode;
   logic [MODE_W-1:0]  mode_m1;
   logic               mode_active;
   logic               has_latch;
   logic               has_under;
   logic [1:0]         over_idx;
   logic [1:0]         latch_idx;
   logic [1:0]         under_idx;
   logic [7:0]         recharge_lim;
   logic [VOLT_W-1:0]  recharge_level;
   logic [VOLT_W-1:0]  cc_level;
   logic [5:0]         over_old;
   logic [7:0]         under_old;
   logic [PHASE_W-1:0] phase_req;

   always_comb begin
      mode        = cfg.charge_mode;
      mode_m1     = mode - 3'd1;
      mode_active = mode inside {[MODE_LEAD:MODE_SIX]};
      has_latch   = mode inside {MODE_LEAD, MODE_AGM, MODE_LITHIUM};
      has_under   = mode inside {MODE_LEAD, MODE_AGM, MODE_SIX};
      over_idx    = mode_m1[1:0];
      latch_idx   = (mode == MODE_LITHIUM) ? 2'd2 : {1'b0, mode_m1[0]};
      under_idx   = (mode == MODE_SIX) ? 2'd2 : {1'b0, mode_m1[0]};
      recharge_lim   = (mode == MODE_AGM) ? AGM_LIM : LONG_LIM;
      recharge_level = (mode == MODE_SIX) ? cfg.six_volt_recharge_level
                                          : cfg.lead_recharge_level;
      cc_level  = has_latch ? latched_ff[latch_idx] : cfg.six_volt_stop_level;
      over_old  = over_ff[over_idx];
      under_old = under_ff[under_idx];

      case (item.phase_request)
         REQ_REMOVAL: phase_req = PHASE_REMOVAL;
         REQ_BATTERY: phase_req = PHASE_BATTERY;
         default:     phase_req = phase_ff;
      endcase

      phase_in   = phase_req;
      current_in = current_ff;
      latched_in = latched_ff;
      over_in    = over_ff;
      under_in   = under_ff;
      result.charger_enable = 1'b0;
      result.stop_threshold = '0;

      if (mode_active) begin
         case (phase_req)
            PHASE_REMOVAL: begin
               current_in = 1'b0;
               over_in[over_idx] = '0;
               if (has_under) begin
                  under_in[under_idx] = '0;
               end
            end
            PHASE_BATTERY: begin
               if (mode == MODE_LITHIUM) begin
                  latched_in[latch_idx] = lithium_level(item.temperature);
               end else if (has_latch) begin
                  latched_in[latch_idx] = lead_level(item.temperature);
               end
               current_in = 1'b0;
               if (!item.fault_present) begin
                  phase_in = PHASE_CC;
                  over_in[over_idx] = '0;
                  if (has_under) begin
                     under_in[under_idx] = '0;
                  end
               end
            end
            PHASE_CC: begin
               result.charger_enable = 1'b1;
               current_in = 1'b1;
               if (item.battery_voltage > cc_level) begin
                  if (over_old < OVER_MAX) begin
                     over_in[over_idx] = over_old + 6'd1;
                  end
                  if (over_old > FULL_LIM) begin
                     phase_in = PHASE_FULL;
                  end
               end
            end
            default: begin
               // full: count ticks below the recharge level (not in lithium mode), restart when past limit
               if (has_under && (item.battery_voltage < recharge_level)) begin
                  if (under_old < UNDER_MAX) begin
                     under_in[under_idx] = under_old + 8'd1;
                  end
                  if (under_old > recharge_lim) begin
                     phase_in = PHASE_CC;
                     under_in[under_idx] = '0;
                     over_in[over_idx]   = '0;
                  end
               end
            end
         endcase
         result.stop_threshold = has_latch ? latched_in[latch_idx] : cfg.six_volt_stop_level;
      end else begin
         current_in = 1'b0;
      end

      result.high_current = current_in;
      result.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_BATTERY;
         current_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            latched_ff[k] <= '0;
            under_ff[k]   <= '0;
         end
         for (int k = 0; k < 4; k++) begin
            over_ff[k] <= '0;
         end
      end else if (step) begin
         phase_ff   <= phase_in;
         current_ff <= current_in;
         latched_ff <= latched_in;
         over_ff    <= over_in;
         under_ff   <= under_in;
      end
   end

endmodule

`default_nettype wire

[src/mmbcc_checker.sv]
// port-level checker for the battery charge controller, bound to the top level
// depends on mmbcc_pkg and multi_mode_battery_charge_controller_defines.svh
`default_nettype none

`include "multi_mode_battery_charge_controller_defines.svh"

module mmbcc_checker
   import mmbcc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic                     rsp_charger_enable,
   input wire logic                     rsp_high_current,
   input wire logic [PHASE_W-1:0]       rsp_phase
);

   // a stalled result beat stays offered
   `MMBCC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "rsp beat dropped while stalled")

   // charging runs at high current, and the tick that reaches full still charges
   `MMBCC_ASSERT(a_enable_cc, rsp_valid && rsp_charger_enable |-> ((rsp_phase == PHASE_CC) || (rsp_phase == PHASE_FULL)) && rsp_high_current, "charger enabled outside constant current")

   // input backs up only behind a waiting result
   `MMBCC_ASSERT(a_stall_cause, req_stall |-> rsp_valid && $past(rsp_valid), "req stalled with no result waiting")

   // reset empties the pipeline
   `MMBCC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

bind multi_mode_battery_charge_controller mmbcc_checker u_mmbcc_checker (.*);

`default_nettype wire
